### design/brl_pkg.sv
// brl_pkg: shared types and constants of the bresenham line rasterizer
// holds the command codes, the queue control struct and the default sizes
// no dependencies
package brl_pkg;

  // default sizes handed to the top level parameters
  localparam int unsigned COORD_BITS_DEF  = 12;
  localparam int unsigned COLOR_BITS_DEF  = 24;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // command carried in tuser of the input stream
  typedef enum logic [0:0] {
    FUNC_LOAD = 1'b0,
    FUNC_STEP = 1'b1
  } func_e;

  // classification of one queued command
  typedef struct packed {
    func_e func;
    logic  step_x_neg;
    logic  step_y_neg;
    logic  x_major;
  } ctrl_t;

endpackage

### design/bresenham_line_rasterizer.sv
// bresenham_line_rasterizer: top level of the pull driven line rasterizer
// ties the front, the command queue and the back together
// depends on brl_pkg, brl_front, brl_fifo and brl_back
//
// Input stream s_axis: tuser selects the command, 0 loads a line (endpoints
// and colour in tdata), 1 asks for the next pixel. A load yields no output
// transaction; a step on an armed line yields one pixel on m_axis, with
// tlast set on the endpoint, after which the line is disarmed. Steps while
// no line is armed are consumed and dropped.
// An accepted step is first written into the queue; the back takes it from
// there and registers its pixel in the output register that drives m_axis.
// Throughput: one transaction per cycle in both directions while m_axis is
// not stalled, set by the error add and compare of the back end step.
// The front and back are parted by a two entry queue; when m_axis stalls
// the back holds its pixel, the queue fills and s_axis_tready falls once it
// is full. Loads keep draining from the queue during a stall.
// Reset: queue empty, output empty, no line armed.
module bresenham_line_rasterizer #(
  parameter int unsigned COORD_BITS = brl_pkg::COORD_BITS_DEF,
  parameter int unsigned COLOR_BITS = brl_pkg::COLOR_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // fields from bit 0: x_start, y_start, x_end, y_end, pixel_color, zero pad
  input  logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
  // fields from bit 0: func
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // fields from bit 0: pixel_x, pixel_y, pixel_color_out, zero pad
  output logic [((2*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
  // last_pixel
  output logic                  m_axis_tlast
);
  import brl_pkg::*;

  localparam int unsigned IN_W    = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_W   = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
  localparam int unsigned ENTRY_W = $bits(ctrl_t) + 6 * COORD_BITS + COLOR_BITS;

  ctrl_t                        f_ctrl, b_ctrl;
  logic signed [COORD_BITS-1:0] f_x0, f_y0, f_x1, f_y1;
  logic signed [COORD_BITS-1:0] b_x0, b_y0, b_x1, b_y1;
  logic [COORD_BITS-1:0]        f_dx, f_dy, b_dx, b_dy;
  logic [COLOR_BITS-1:0]        f_color, b_color;
  logic [ENTRY_W-1:0]           q_wdata, q_rdata;
  logic                         q_valid;
  logic                         q_pop;
  logic                         active;
  logic signed [COORD_BITS-1:0] pix_x, pix_y;
  logic [COLOR_BITS-1:0]        pix_color;

  // front: classify and precompute
  brl_front #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS),
    .IN_W       (IN_W)
  ) u_front (
    .tdata_i (s_axis_tdata),
    .tuser_i (s_axis_tuser[0]),
    .ctrl_o  (f_ctrl),
    .x0_o    (f_x0),
    .y0_o    (f_y0),
    .x1_o    (f_x1),
    .y1_o    (f_y1),
    .dx_o    (f_dx),
    .dy_o    (f_dy),
    .color_o (f_color)
  );

  // command queue
  assign q_wdata = {f_color, f_dy, f_dx, f_y1, f_x1, f_y0, f_x0, f_ctrl};

  brl_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .wdata_i (q_wdata),
    .ready_o (s_axis_tready),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .valid_o (q_valid)
  );

  assign {b_color, b_dy, b_dx, b_y1, b_x1, b_y0, b_x0, b_ctrl} = q_rdata;

  // back: line stepping and output register
  brl_back #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .ctrl_i      (b_ctrl),
    .x0_i        (b_x0),
    .y0_i        (b_y0),
    .x1_i        (b_x1),
    .y1_i        (b_y1),
    .dx_i        (b_dx),
    .dy_i        (b_dy),
    .color_i     (b_color),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .pix_x_o     (pix_x),
    .pix_y_o     (pix_y),
    .pix_color_o (pix_color),
    .pix_last_o  (m_axis_tlast),
    .active_o    (active)
  );

  assign m_axis_tdata = OUT_W'({pix_color, pix_y, pix_x});

  // the back never takes a command from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("queue popped while empty");

  // a step that would emit is never taken while the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (q_pop && (b_ctrl.func == FUNC_STEP) && active) |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("pixel emitted over a stalled output");

  // a new pixel appears only after an armed step left the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(q_pop && active))
    else $error("pixel emitted without a step");

endmodule

### design/brl_front.sv
// brl_front: input side of the line rasterizer, classifies each command
// and works out the deltas, step signs and major axis of a load
// depends on brl_pkg
module brl_front #(
  parameter int unsigned COORD_BITS = brl_pkg::COORD_BITS_DEF,
  parameter int unsigned COLOR_BITS = brl_pkg::COLOR_BITS_DEF,
  parameter int unsigned IN_W       = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8
) (
  input  logic [IN_W-1:0]              tdata_i,
  input  logic                         tuser_i,
  output brl_pkg::ctrl_t               ctrl_o,
  output logic signed [COORD_BITS-1:0] x0_o,
  output logic signed [COORD_BITS-1:0] y0_o,
  output logic signed [COORD_BITS-1:0] x1_o,
  output logic signed [COORD_BITS-1:0] y1_o,
  output logic [COORD_BITS-1:0]        dx_o,
  output logic [COORD_BITS-1:0]        dy_o,
  output logic [COLOR_BITS-1:0]        color_o
);
  import brl_pkg::*;

  logic signed [COORD_BITS:0] diff_x;
  logic signed [COORD_BITS:0] diff_y;
  logic [COORD_BITS:0]        abs_x;
  logic [COORD_BITS:0]        abs_y;

  // unpack the transaction fields
  assign x0_o    = tdata_i[COORD_BITS-1:0];
  assign y0_o    = tdata_i[2*COORD_BITS-1:COORD_BITS];
  assign x1_o    = tdata_i[3*COORD_BITS-1:2*COORD_BITS];
  assign y1_o    = tdata_i[4*COORD_BITS-1:3*COORD_BITS];
  assign color_o = tdata_i[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];

  // signed differences, one bit wider so they never overflow
  assign diff_x = {x1_o[COORD_BITS-1], x1_o} - {x0_o[COORD_BITS-1], x0_o};
  assign diff_y = {y1_o[COORD_BITS-1], y1_o} - {y0_o[COORD_BITS-1], y0_o};

  // magnitudes fit the coordinate width
  assign abs_x = diff_x[COORD_BITS] ? -diff_x : diff_x;
  assign abs_y = diff_y[COORD_BITS] ? -diff_y : diff_y;
  assign dx_o  = abs_x[COORD_BITS-1:0];
  assign dy_o  = abs_y[COORD_BITS-1:0];

  // command classification, step negative unless start lies below end
  always_comb begin
    ctrl_o.func       = func_e'(tuser_i);
    ctrl_o.step_x_neg = diff_x[COORD_BITS] || (diff_x == '0);
    ctrl_o.step_y_neg = diff_y[COORD_BITS] || (diff_y == '0);
    ctrl_o.x_major    = dx_o > dy_o;
  end

endmodule

### design/brl_fifo.sv
// brl_fifo: short command queue between the front and back of the rasterizer
// register based, one write and one read port, no dependencies
module brl_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             valid_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign ready_o = count_q != FULL_CNT;
  assign valid_o = count_q != '0;
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill level update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### design/brl_back.sv
// brl_back: execution side of the rasterizer, holds the line state, runs
// one bresenham step per cycle unless the output is stalled and drives the
// registered pixel output; depends on brl_pkg
module brl_back #(
  parameter int unsigned COORD_BITS = brl_pkg::COORD_BITS_DEF,
  parameter int unsigned COLOR_BITS = brl_pkg::COLOR_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  output logic                         q_pop_o,
  input  brl_pkg::ctrl_t               ctrl_i,
  input  logic signed [COORD_BITS-1:0] x0_i,
  input  logic signed [COORD_BITS-1:0] y0_i,
  input  logic signed [COORD_BITS-1:0] x1_i,
  input  logic signed [COORD_BITS-1:0] y1_i,
  input  logic [COORD_BITS-1:0]        dx_i,
  input  logic [COORD_BITS-1:0]        dy_i,
  input  logic [COLOR_BITS-1:0]        color_i,
  input  logic                         m_ready_i,
  output logic                         m_valid_o,
  output logic signed [COORD_BITS-1:0] pix_x_o,
  output logic signed [COORD_BITS-1:0] pix_y_o,
  output logic [COLOR_BITS-1:0]        pix_color_o,
  output logic                         pix_last_o,
  output logic                         active_o
);
  import brl_pkg::*;

  localparam int unsigned ERR_W = COORD_BITS + 2;
  localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

  // line state
  logic signed [COORD_BITS-1:0] cur_x_q, cur_x_d;
  logic signed [COORD_BITS-1:0] cur_y_q, cur_y_d;
  logic signed [COORD_BITS-1:0] tgt_x_q, tgt_x_d;
  logic signed [COORD_BITS-1:0] tgt_y_q, tgt_y_d;
  logic [COORD_BITS-1:0]        dx_q, dx_d;
  logic [COORD_BITS-1:0]        dy_q, dy_d;
  logic                         sx_neg_q, sx_neg_d;
  logic                         sy_neg_q, sy_neg_d;
  logic                         x_major_q, x_major_d;
  logic signed [ERR_W-1:0]      err_q, err_d;
  logic [COLOR_BITS-1:0]        color_q, color_d;
  logic                         active_q, active_d;

  // output register
  logic                         m_valid_q, m_valid_d;
  logic signed [COORD_BITS-1:0] pix_x_q, pix_x_d;
  logic signed [COORD_BITS-1:0] pix_y_q, pix_y_d;
  logic [COLOR_BITS-1:0]        pix_color_q, pix_color_d;
  logic                         pix_last_q, pix_last_d;

  // step datapath
  logic                         out_free;
  logic                         is_load;
  logic                         emit;
  logic                         at_end;
  logic [COORD_BITS-1:0]        major;
  logic [COORD_BITS-1:0]        minor;
  logic signed [ERR_W-1:0]      err_add;
  logic signed [ERR_W:0]        err_twice;
  logic                         minor_move;
  logic [COORD_BITS-1:0]        inc_x;
  logic [COORD_BITS-1:0]        inc_y;

  assign out_free = !m_valid_q || m_ready_i;
  assign is_load  = ctrl_i.func == FUNC_LOAD;
  assign q_pop_o  = q_valid_i && (is_load || !active_q || out_free);
  assign emit     = q_pop_o && !is_load && active_q;
  assign at_end   = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);

  // error term: add the minor delta, compare twice the error to the major delta
  assign major      = x_major_q ? dx_q : dy_q;
  assign minor      = x_major_q ? dy_q : dx_q;
  assign err_add    = err_q + $signed({2'b00, minor});
  assign err_twice  = {err_add, 1'b0};
  assign minor_move = err_twice > $signed({3'b000, major});
  assign inc_x      = sx_neg_q ? '1 : ONE;
  assign inc_y      = sy_neg_q ? '1 : ONE;

  // next state of line and output register
  always_comb begin
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    tgt_x_d     = tgt_x_q;
    tgt_y_d     = tgt_y_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    sx_neg_d    = sx_neg_q;
    sy_neg_d    = sy_neg_q;
    x_major_d   = x_major_q;
    err_d       = err_q;
    color_d     = color_q;
    active_d    = active_q;
    m_valid_d   = m_ready_i ? 1'b0 : m_valid_q;
    pix_x_d     = pix_x_q;
    pix_y_d     = pix_y_q;
    pix_color_d = pix_color_q;
    pix_last_d  = pix_last_q;
    if (q_pop_o && is_load) begin
      cur_x_d   = x0_i;
      cur_y_d   = y0_i;
      tgt_x_d   = x1_i;
      tgt_y_d   = y1_i;
      dx_d      = dx_i;
      dy_d      = dy_i;
      sx_neg_d  = ctrl_i.step_x_neg;
      sy_neg_d  = ctrl_i.step_y_neg;
      x_major_d = ctrl_i.x_major;
      err_d     = '0;
      color_d   = color_i;
      active_d  = 1'b1;
    end else if (emit) begin
      m_valid_d   = 1'b1;
      pix_x_d     = cur_x_q;
      pix_y_d     = cur_y_q;
      pix_color_d = color_q;
      pix_last_d  = at_end;
      if (at_end) begin
        active_d = 1'b0;
      end else begin
        err_d = minor_move ? err_add - $signed({2'b00, major}) : err_add;
        if (x_major_q || minor_move) begin
          cur_x_d = cur_x_q + inc_x;
        end
        if (!x_major_q || minor_move) begin
          cur_y_d = cur_y_q + inc_y;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      active_q  <= active_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_x_q     <= cur_x_d;
    cur_y_q     <= cur_y_d;
    tgt_x_q     <= tgt_x_d;
    tgt_y_q     <= tgt_y_d;
    dx_q        <= dx_d;
    dy_q        <= dy_d;
    sx_neg_q    <= sx_neg_d;
    sy_neg_q    <= sy_neg_d;
    x_major_q   <= x_major_d;
    err_q       <= err_d;
    color_q     <= color_d;
    pix_x_q     <= pix_x_d;
    pix_y_q     <= pix_y_d;
    pix_color_q <= pix_color_d;
    pix_last_q  <= pix_last_d;
  end

  assign m_valid_o   = m_valid_q;
  assign pix_x_o     = pix_x_q;
  assign pix_y_o     = pix_y_q;
  assign pix_color_o = pix_color_q;
  assign pix_last_o  = pix_last_q;
  assign active_o    = active_q;

endmodule

### test/bresenham_line_rasterizer_test.sv
`timescale 1ns / 100ps
// bresenham_line_rasterizer_test: self-checking testbench of the line rasterizer
// predicts every pixel with its own line tracker and compares the output stream
// depends on brl_pkg and bresenham_line_rasterizer
module bresenham_line_rasterizer_test;
  import brl_pkg::*;

  localparam int unsigned CW = 12;
  localparam int unsigned KW = 24;
  localparam int unsigned SW = ((4*CW+KW+7)/8)*8;
  localparam int unsigned MW = ((2*CW+KW+7)/8)*8;

  // one pixel as it leaves the block
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [KW-1:0]        color;
    logic                 last;
  } pixel_t;

  // tracks the armed line and holds the pixels still to come
  class line_tracker;
    logic signed [CW-1:0]   cur_x, cur_y, target_x, target_y;
    logic [CW-1:0]          delta_x, delta_y;
    logic                   step_x_neg, step_y_neg, x_major;
    logic signed [CW+1:0]   error_acc;
    logic [KW-1:0]          line_color;
    bit                     armed;
    pixel_t                 pending_pixels[$];
    int                     errors;

    function new();
      cur_x = '0; cur_y = '0; target_x = '0; target_y = '0;
      delta_x = '0; delta_y = '0;
      step_x_neg = 1'b0; step_y_neg = 1'b0; x_major = 1'b0;
      error_acc = '0; line_color = '0;
      armed = 1'b0;
      errors = 0;
    endfunction

    // apply one accepted command, returns 1 when it yields a pixel
    function bit take_command(func_e func, logic [SW-1:0] data);
      logic signed [CW-1:0] x0, y0, x1, y1;
      int dx, dy;
      pixel_t pix;
      x0 = data[CW-1:0];
      y0 = data[2*CW-1:CW];
      x1 = data[3*CW-1:2*CW];
      y1 = data[4*CW-1:3*CW];
      if (func == FUNC_LOAD) begin
        dx = int'(x1) - int'(x0);
        dy = int'(y1) - int'(y0);
        cur_x = x0; cur_y = y0;
        target_x = x1; target_y = y1;
        delta_x = CW'(dx < 0 ? -dx : dx);
        delta_y = CW'(dy < 0 ? -dy : dy);
        step_x_neg = !(x0 < x1);
        step_y_neg = !(y0 < y1);
        x_major = delta_x > delta_y;
        error_acc = '0;
        line_color = data[4*CW+KW-1:4*CW];
        armed = 1'b1;
        return 1'b0;
      end
      // steps on an idle rasterizer are dropped
      if (!armed) return 1'b0;
      pix.x = cur_x;
      pix.y = cur_y;
      pix.color = line_color;
      pix.last = (cur_x == target_x) && (cur_y == target_y);
      pending_pixels = {pending_pixels, pix};
      if (pix.last) begin
        armed = 1'b0;
        return 1'b1;
      end
      // advance along the major axis, minor axis on error overflow
      if (x_major) begin
        cur_x += step_x_neg ? -12'sd1 : 12'sd1;
        error_acc += $signed({2'b00, delta_y});
        if (2 * int'(error_acc) > int'(delta_x)) begin
          error_acc -= $signed({2'b00, delta_x});
          cur_y += step_y_neg ? -12'sd1 : 12'sd1;
        end
      end else begin
        cur_y += step_y_neg ? -12'sd1 : 12'sd1;
        error_acc += $signed({2'b00, delta_x});
        if (2 * int'(error_acc) > int'(delta_y)) begin
          error_acc -= $signed({2'b00, delta_y});
          cur_x += step_x_neg ? -12'sd1 : 12'sd1;
        end
      end
      return 1'b1;
    endfunction

    // compare one output transaction with the oldest predicted pixel
    function void check_pixel(logic [MW-1:0] data, logic last);
      pixel_t want;
      pixel_t got;
      got.x = data[CW-1:0];
      got.y = data[2*CW-1:CW];
      got.color = data[2*CW+KW-1:2*CW];
      got.last = last;
      if (pending_pixels.size() == 0) begin
        $display("%0t: pixel expected none actual x=%0d y=%0d colour=%h last=%b",
                 $time, got.x, got.y, got.color, got.last);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      if (got.x !== want.x) begin
        $display("%0t: pixel_x expected %0d actual %0d", $time, want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: pixel_y expected %0d actual %0d", $time, want.y, got.y);
        errors++;
      end
      if (got.color !== want.color) begin
        $display("%0t: pixel_color_out expected %h actual %h", $time, want.color, got.color);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last_pixel expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  // fields from bit 0: x_start, y_start, x_end, y_end, pixel_color
  logic [SW-1:0] s_axis_tdata;
  // fields from bit 0: func
  logic [0:0]    s_axis_tuser;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  // fields from bit 0: pixel_x, pixel_y, pixel_color_out, zero pad
  logic [MW-1:0] m_axis_tdata;
  // last_pixel
  logic          m_axis_tlast;

  line_tracker tracker = new();
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          useful_items = 0;

  bresenham_line_rasterizer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver back-pressure, changed on the falling edge
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.check_pixel(m_axis_tdata, m_axis_tlast);
  end

  // run limit
  initial begin
    #5ms;
    $display("bresenham_line_rasterizer: mismatch");
    $finish;
  end

  // one input transaction, entered and left on a falling edge
  task automatic send_item(input func_e func, input logic [SW-1:0] data);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (tracker.take_command(func, data) || func == FUNC_LOAD) useful_items++;
    @(negedge clk_i);
  endtask

  task automatic send_load(input int x0, input int y0, input int x1, input int y1,
                           input logic [KW-1:0] color);
    send_item(FUNC_LOAD, {color, CW'(y1), CW'(x1), CW'(y0), CW'(x0)});
  endtask

  // step with junk in the unused data field
  task automatic send_step();
    send_item(FUNC_STEP, SW'({$urandom, $urandom, $urandom}));
  endtask

  task automatic finish_line();
    while (tracker.armed) send_step();
  endtask

  // hold the sender off until every predicted pixel has arrived
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (tracker.pending_pixels.size() != 0) @(negedge clk_i);
  endtask

  function automatic int rand_coord();
    return int'($urandom_range(4095)) - 2048;
  endfunction

  // pick an end point near the start, mirrored back into range
  function automatic int near(int a, int d);
    int b;
    b = a + d;
    if (b > 2047 || b < -2048) b = a - d;
    return b;
  endfunction

  // well formed line with random content, sometimes abandoned part way
  task automatic random_line();
    int span, dx, dy, x0, y0, shape, cut;
    span = ($urandom_range(19) == 0) ? 64 : 10;
    dx = int'($urandom_range(2*span)) - span;
    dy = int'($urandom_range(2*span)) - span;
    shape = $urandom_range(5);
    if (shape == 0) dy = 0;
    else if (shape == 1) dx = 0;
    else if (shape == 2) dy = ($urandom_range(1) == 1) ? dx : -dx;
    x0 = rand_coord();
    y0 = rand_coord();
    send_load(x0, y0, near(x0, dx), near(y0, dy), KW'($urandom));
    cut = ($urandom_range(9) == 0) ? int'($urandom_range(4)) : -1;
    while (tracker.armed && cut != 0) begin
      send_step();
      cut--;
    end
    if ($urandom_range(3) == 0) send_step();
  endtask

  // loads across the whole field range and stray steps
  task automatic random_noise();
    int n;
    if ($urandom_range(2) == 0) begin
      send_step();
    end else begin
      send_load(rand_coord(), rand_coord(), rand_coord(), rand_coord(), KW'($urandom));
      n = $urandom_range(3);
      repeat (n) send_step();
    end
  endtask

  // stimulus
  initial begin
    int phase;
    int next_switch;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = FUNC_LOAD;
    s_axis_tdata = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: step before any load, single pixel line, extremes,
    // abandoned lines, flat and steep lines, steps after the endpoint
    send_step();
    send_load(0, 0, 0, 0, 24'h123456);
    send_step();
    send_step();
    send_load(-2048, 2047, 2047, -2048, 24'hffffff);
    send_step();
    send_step();
    send_load(2047, -2048, -2048, 2047, 24'h000000);
    send_step();
    send_load(-2048, -2048, -2048, -2048, 24'h800001);
    finish_line();
    send_load(3, 5, -1, 5, 24'ha5a5a5);
    finish_line();
    send_step();
    send_load(0, 0, 1, 3, 24'h5a5a5a);
    finish_line();
    send_load(2047, 2047, 2044, 2047, 24'h7fffff);
    finish_line();
    drain();

    // random part, rotating through the idling phases
    phase = 0;
    next_switch = useful_items + 120;
    while (useful_items < 850) begin
      if ($urandom_range(3) == 0) random_noise();
      else random_line();
      if (useful_items >= next_switch) begin
        drain();
        phase = (phase + 1) % 4;
        idle_pct  = (phase == 1) ? 54 : (phase == 3) ? 11 : 0;
        stall_pct = (phase == 2) ? 54 : (phase == 3) ? 11 : 0;
        next_switch = useful_items + 120;
      end
    end
    s_axis_tvalid <= 1'b0;

    // wait for the last pixels, then let the pipeline settle
    while (tracker.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0)
      $display("bresenham_line_rasterizer: match");
    else
      $display("bresenham_line_rasterizer: mismatch");
    $finish;
  end

endmodule
